// ===== design/assert_macros.svh =====
// Assertion helpers shared by the checkers.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEEO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEEO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/meeo_pkg.sv =====
`timescale 1ns / 1ps

package meeo_pkg;

  localparam int MaxDimDefault = 16;

  localparam int DataW   = 32;
  localparam int CmdW    = 3;
  localparam int IdxW    = 4;
  localparam int SpanW   = 5;
  localparam int StatusW = 2;
  localparam int CfgW    = 5;
  localparam int CfgIdxW = 1;

  localparam logic [CfgW-1:0] CountReset = CfgW'(16);

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxW-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_COL_COUNT = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EQUAL = 2'd1;
  localparam logic [StatusW-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_SWAP_ROW  = 3'd2,
    CMD_SWAP_COL  = 3'd3,
    CMD_ADD_ROW   = 3'd4,
    CMD_ADD_COL   = 3'd5,
    CMD_SCALE_ROW = 3'd6,
    CMD_SCALE_COL = 3'd7
  } cmd_e;

  // Kind of work done per position by the arithmetic pipeline.
  typedef enum logic [1:0] {
    OP_SWAP  = 2'd0,
    OP_ADD   = 2'd1,
    OP_SCALE = 2'd2
  } op_e;

  typedef struct packed {
    logic        [CmdW-1:0]  command;
    logic        [IdxW-1:0]  first_index;
    logic        [IdxW-1:0]  second_index;
    logic signed [DataW-1:0] factor;
    logic        [SpanW-1:0] span_start;
    logic        [SpanW-1:0] span_end;
    logic signed [DataW-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0]   read_value;
    logic        [StatusW-1:0] status;
  } result_t;

  typedef struct packed {
    logic valid;
    op_e  op;
  } issue_t;

endpackage

// ===== design/meeo_ram.sv =====
`timescale 1ns / 1ps

module meeo_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/meeo_ctrl.sv =====
`timescale 1ns / 1ps

module meeo_ctrl #(
  parameter int MAX_DIM = meeo_pkg::MaxDimDefault,
  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM),
  localparam int PosW = ($clog2(MAX_DIM + 1) > meeo_pkg::SpanW) ?
                        $clog2(MAX_DIM + 1) : meeo_pkg::SpanW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  meeo_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output meeo_pkg::result_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [meeo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [meeo_pkg::CfgW-1:0]     cfg_data_i,
  output logic [AddrW-1:0]              raddr_a_o,
  output logic [AddrW-1:0]              raddr_b_o,
  input  logic [meeo_pkg::DataW-1:0]    rdata_a_i,
  output logic                          we_o,
  output logic [AddrW-1:0]              waddr_o,
  output logic [meeo_pkg::DataW-1:0]    wdata_o,
  output meeo_pkg::issue_t              issue_o,
  output logic [meeo_pkg::DataW-1:0]    factor_o,
  input  logic                          pipe_busy_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StWalk = 2'd2;

  localparam logic [PosW-1:0] DimMax = PosW'(MAX_DIM);

  logic [1:0]                    state_q, state_d;
  logic                          done_q, done_d;
  logic [meeo_pkg::CfgW-1:0]     row_count_q, row_count_d;
  logic [meeo_pkg::CfgW-1:0]     col_count_q, col_count_d;
  logic [PosW-1:0]               pos_q, pos_d;
  logic [PosW-1:0]               end_q, end_d;
  logic                          gap_q, gap_d;
  meeo_pkg::op_e                 op_q, op_d;
  logic                          is_col_q, is_col_d;
  logic [meeo_pkg::IdxW-1:0]     idx_a_q, idx_a_d;
  logic [meeo_pkg::IdxW-1:0]     idx_b_q, idx_b_d;
  logic [meeo_pkg::DataW-1:0]    factor_q, factor_d;
  meeo_pkg::result_t             result_q, result_d;

  logic            accept;
  logic            issue;
  logic [PosW-1:0] rows_eff, cols_eff, idim, plen;
  logic [PosW-1:0] a_ext, b_ext, hi_ext, hi_clip;
  logic            is_elem, is_col, is_add, is_scale;
  logic            elem_bad, op_bad, equal_idx;

  function automatic logic [AddrW-1:0] addr_of(logic [PosW-1:0] r, logic [PosW-1:0] c);
    addr_of = AddrW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // Clip the dimension registers to the storage size.
  assign rows_eff = (PosW'(row_count_q) > DimMax) ? DimMax : PosW'(row_count_q);
  assign cols_eff = (PosW'(col_count_q) > DimMax) ? DimMax : PosW'(col_count_q);

  assign is_elem  = cmd_i.command inside {meeo_pkg::CMD_WRITE, meeo_pkg::CMD_READ};
  assign is_col   = cmd_i.command inside {meeo_pkg::CMD_SWAP_COL, meeo_pkg::CMD_ADD_COL,
                                          meeo_pkg::CMD_SCALE_COL};
  assign is_add   = cmd_i.command inside {meeo_pkg::CMD_ADD_ROW, meeo_pkg::CMD_ADD_COL};
  assign is_scale = cmd_i.command inside {meeo_pkg::CMD_SCALE_ROW, meeo_pkg::CMD_SCALE_COL};

  assign a_ext   = PosW'(cmd_i.first_index);
  assign b_ext   = PosW'(cmd_i.second_index);
  assign idim    = is_col ? cols_eff : rows_eff;
  assign plen    = is_col ? rows_eff : cols_eff;
  assign hi_ext  = PosW'(cmd_i.span_end);
  assign hi_clip = (hi_ext > plen) ? plen : hi_ext;

  assign elem_bad  = (a_ext >= rows_eff) || (b_ext >= cols_eff);
  assign op_bad    = (a_ext >= idim) || (!is_scale && (b_ext >= idim));
  assign equal_idx = is_add && (cmd_i.first_index == cmd_i.second_index);

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    pos_d       = pos_q;
    end_d       = end_q;
    gap_d       = 1'b0;
    op_d        = op_q;
    is_col_d    = is_col_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    factor_d    = factor_q;
    result_d    = result_q;
    issue       = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        meeo_pkg::REG_ROW_COUNT: row_count_d = cfg_data_i;
        meeo_pkg::REG_COL_COUNT: col_count_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          result_d.read_value = '0;
          result_d.status     = meeo_pkg::STATUS_DONE;
          if (is_elem) begin
            if (elem_bad) begin
              result_d.status = meeo_pkg::STATUS_RANGE;
              done_d          = 1'b1;
            end else if (cmd_i.command == meeo_pkg::CMD_READ) begin
              state_d = StRead;
            end else begin
              done_d = 1'b1;
            end
          end else if (op_bad) begin
            result_d.status = meeo_pkg::STATUS_RANGE;
            done_d          = 1'b1;
          end else if (equal_idx) begin
            result_d.status = meeo_pkg::STATUS_EQUAL;
            done_d          = 1'b1;
          end else begin
            state_d  = StWalk;
            is_col_d = is_col;
            idx_a_d  = cmd_i.first_index;
            idx_b_d  = cmd_i.second_index;
            factor_d = cmd_i.factor;
            pos_d    = PosW'(cmd_i.span_start);
            end_d    = hi_clip;
            if (is_add) begin
              op_d = meeo_pkg::OP_ADD;
            end else if (is_scale) begin
              op_d = meeo_pkg::OP_SCALE;
            end else begin
              op_d = meeo_pkg::OP_SWAP;
            end
          end
        end
      end
      StRead: begin
        result_d.read_value = rdata_a_i;
        done_d              = 1'b1;
        state_d             = StIdle;
      end
      StWalk: begin
        if (gap_q) begin
          // Hold after a swap position: it needs two write slots.
        end else if (pos_q < end_q) begin
          issue = 1'b1;
          pos_d = pos_q + PosW'(1);
          gap_d = (op_q == meeo_pkg::OP_SWAP);
        end else if (!pipe_busy_i) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Read addresses: element access in idle, span positions while walking.
  always_comb begin
    if (state_q == StWalk) begin
      if (is_col_q) begin
        raddr_a_o = addr_of(pos_q, PosW'(idx_a_q));
        raddr_b_o = addr_of(pos_q, PosW'(idx_b_q));
      end else begin
        raddr_a_o = addr_of(PosW'(idx_a_q), pos_q);
        raddr_b_o = addr_of(PosW'(idx_b_q), pos_q);
      end
    end else begin
      raddr_a_o = addr_of(a_ext, b_ext);
      raddr_b_o = addr_of(a_ext, b_ext);
    end
  end

  assign we_o    = accept && (cmd_i.command == meeo_pkg::CMD_WRITE) && !elem_bad;
  assign waddr_o = addr_of(a_ext, b_ext);
  assign wdata_o = cmd_i.write_value;

  assign issue_o.valid = issue;
  assign issue_o.op    = op_q;
  assign factor_o      = factor_q;

  assign done_o   = done_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      done_q      <= 1'b0;
      row_count_q <= meeo_pkg::CountReset;
      col_count_q <= meeo_pkg::CountReset;
      pos_q       <= '0;
      end_q       <= '0;
      gap_q       <= 1'b0;
      op_q        <= meeo_pkg::OP_SWAP;
      is_col_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
      pos_q       <= pos_d;
      end_q       <= end_d;
      gap_q       <= gap_d;
      op_q        <= op_d;
      is_col_q    <= is_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q  <= idx_a_d;
    idx_b_q  <= idx_b_d;
    factor_q <= factor_d;
    result_q <= result_d;
  end

endmodule

// ===== design/meeo_alu.sv =====
`timescale 1ns / 1ps

module meeo_alu #(
  parameter int MAX_DIM = meeo_pkg::MaxDimDefault,
  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  meeo_pkg::issue_t           issue_i,
  input  logic [AddrW-1:0]           raddr_a_i,
  input  logic [AddrW-1:0]           raddr_b_i,
  input  logic [meeo_pkg::DataW-1:0] factor_i,
  input  logic [meeo_pkg::DataW-1:0] rdata_a_i,
  input  logic [meeo_pkg::DataW-1:0] rdata_b_i,
  output logic                       we_o,
  output logic [AddrW-1:0]           waddr_o,
  output logic [meeo_pkg::DataW-1:0] wdata_o,
  output logic                       busy_o
);

  localparam int DataW = meeo_pkg::DataW;
  localparam int ProdW = 2 * DataW;
  localparam logic signed [ProdW-1:0] SatMax = ProdW'({1'b0, {(DataW-1){1'b1}}});
  localparam logic signed [ProdW-1:0] SatMin = -ProdW'({1'b1, {(DataW-1){1'b0}}});

  // Stage 1: memory data in flight.
  logic                 s1_valid_q;
  meeo_pkg::op_e        s1_op_q;
  logic [AddrW-1:0]     s1_addr_a_q, s1_addr_b_q;
  // Stage 2: product registered, write slot.
  logic                 s2_valid_q;
  meeo_pkg::op_e        s2_op_q;
  logic [AddrW-1:0]     s2_addr_a_q, s2_addr_b_q;
  logic signed [ProdW-1:0] s2_prod_q;
  logic [DataW-1:0]     s2_x_q, s2_y_q;
  // Stage 3: second write of a swap.
  logic                 s3_valid_q;
  logic [AddrW-1:0]     s3_addr_q;
  logic [DataW-1:0]     s3_data_q;

  logic signed [DataW-1:0] a_s, k_s;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] shifted;
  logic [DataW-1:0]        qsat;
  logic signed [DataW:0]   sum;
  logic [DataW-1:0]        sum_sat;

  assign a_s  = rdata_a_i;
  assign k_s  = factor_i;
  assign prod = a_s * k_s;

  // Floor the product to Q16.16 and clamp to the word range.
  always_comb begin
    shifted = s2_prod_q >>> 16;
    if (shifted > SatMax) begin
      qsat = {1'b0, {(DataW-1){1'b1}}};
    end else if (shifted < SatMin) begin
      qsat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      qsat = shifted[DataW-1:0];
    end
  end

  assign sum = $signed({s2_y_q[DataW-1], s2_y_q}) + $signed({qsat[DataW-1], qsat});

  always_comb begin
    if (sum[DataW] != sum[DataW-1]) begin
      sum_sat = sum[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sum_sat = sum[DataW-1:0];
    end
  end

  always_comb begin
    we_o    = 1'b0;
    waddr_o = s2_addr_a_q;
    wdata_o = s2_y_q;
    if (s3_valid_q) begin
      we_o    = 1'b1;
      waddr_o = s3_addr_q;
      wdata_o = s3_data_q;
    end else if (s2_valid_q) begin
      case (s2_op_q)
        meeo_pkg::OP_SWAP: begin
          we_o    = 1'b1;
          waddr_o = s2_addr_a_q;
          wdata_o = s2_y_q;
        end
        meeo_pkg::OP_ADD: begin
          we_o    = 1'b1;
          waddr_o = s2_addr_b_q;
          wdata_o = sum_sat;
        end
        meeo_pkg::OP_SCALE: begin
          we_o    = 1'b1;
          waddr_o = s2_addr_a_q;
          wdata_o = qsat;
        end
        default: we_o = 1'b0;
      endcase
    end
  end

  assign busy_o = s1_valid_q || s2_valid_q || s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q && (s2_op_q == meeo_pkg::OP_SWAP);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q     <= issue_i.op;
    s1_addr_a_q <= raddr_a_i;
    s1_addr_b_q <= raddr_b_i;
    s2_op_q     <= s1_op_q;
    s2_addr_a_q <= s1_addr_a_q;
    s2_addr_b_q <= s1_addr_b_q;
    s2_prod_q   <= prod;
    s2_x_q      <= rdata_a_i;
    s2_y_q      <= rdata_b_i;
    s3_addr_q   <= s2_addr_b_q;
    s3_data_q   <= s2_x_q;
  end

endmodule

// ===== design/matrix_elementary_ops_engine_top.sv =====
`timescale 1ns / 1ps

// Matrix engine for elementary row and column operations on Q16.16 words.
// Command channel: drive an item on cmd_i and raise start; it is taken at a
// rising edge where start is high and busy is low. Exactly one result per item
// appears on result_o for one cycle, flagged by done_o; the receiver cannot
// stall it, so capture it in that cycle.
// Config channel: cfg_valid_i with cfg_index_i (0 row count, 1 column count) and
// cfg_data_i; cfg_ready_o is always high. Write only while the engine is idle.
// A write, or any command rejected for range or equal indices, answers
// straight from idle; a read makes one memory read first. Add and scale
// feed one position into the pipeline per cycle; a swap needs two writes
// per position, which share one memory write port, so its positions enter
// with a hold after each. A span command, also one whose clipped span is
// empty, signals done_o once the pipeline has drained.
// The next item is taken once busy drops, which happens in the cycle done_o shows.
// Reset: row and column counts return to 16 and control clears; matrix
// contents stay undefined until written, with no clearing pass.
module matrix_elementary_ops_engine_top #(
  parameter int MAX_DIM = meeo_pkg::MaxDimDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  meeo_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output meeo_pkg::result_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [meeo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [meeo_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM);
  localparam int Depth = MAX_DIM * MAX_DIM;

  // Read ports are shared: port a serves element reads and span source,
  // port b the span target.
  logic [AddrW-1:0]           raddr_a, raddr_b;
  logic [meeo_pkg::DataW-1:0] rdata_a, rdata_b;

  // Element writes come from control while idle, span writes from the pipeline.
  logic                       ctrl_we, alu_we, mem_we;
  logic [AddrW-1:0]           ctrl_waddr, alu_waddr, mem_waddr;
  logic [meeo_pkg::DataW-1:0] ctrl_wdata, alu_wdata, mem_wdata;

  meeo_pkg::issue_t           issue;
  logic [meeo_pkg::DataW-1:0] factor;
  logic                       pipe_busy;

  meeo_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .rdata_a_i   (rdata_a),
    .we_o        (ctrl_we),
    .waddr_o     (ctrl_waddr),
    .wdata_o     (ctrl_wdata),
    .issue_o     (issue),
    .factor_o    (factor),
    .pipe_busy_i (pipe_busy)
  );

  meeo_alu #(
    .MAX_DIM(MAX_DIM)
  ) u_alu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .factor_i  (factor),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .we_o      (alu_we),
    .waddr_o   (alu_waddr),
    .wdata_o   (alu_wdata),
    .busy_o    (pipe_busy)
  );

  // The two writers never overlap: element writes happen only at acceptance,
  // when the pipeline is empty.
  assign mem_we    = ctrl_we || alu_we;
  assign mem_waddr = ctrl_we ? ctrl_waddr : alu_waddr;
  assign mem_wdata = ctrl_we ? ctrl_wdata : alu_wdata;

  meeo_ram #(
    .Width(meeo_pkg::DataW),
    .Depth(Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

endmodule

// ===== design/meeo_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module meeo_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input meeo_pkg::cmd_t                cmd_i,
  input logic                          done_o,
  input meeo_pkg::result_t             result_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  logic write_taken;
  logic status_known;
  logic error_shown;
  logic cfg_taken;

  assign write_taken  = start && !busy && (cmd_i.command == meeo_pkg::CMD_WRITE);
  assign status_known = (result_o.status == meeo_pkg::STATUS_DONE) ||
                        (result_o.status == meeo_pkg::STATUS_EQUAL) ||
                        (result_o.status == meeo_pkg::STATUS_RANGE);
  assign error_shown  = done_o && (result_o.status != meeo_pkg::STATUS_DONE);
  assign cfg_taken    = cfg_valid_i && cfg_ready_o;

  // A write item, accepted or rejected, answers in the next cycle.
  `MEEO_ASSERT_NEXT(a_write_answers, write_taken, done_o, "write item gave no result")
  // A result is shown only once the engine is free again.
  `MEEO_ASSERT_SAME(a_done_idle, done_o, !busy, "result shown while busy")
  // Status carries one of the three defined codes.
  `MEEO_ASSERT_SAME(a_status_code, done_o, status_known, "undefined status")
  // A failed command reads as zero.
  `MEEO_ASSERT_SAME(a_error_zero, error_shown, result_o.read_value == '0, "error result with data")
  // The user must write configuration only while the engine is idle; the engine does not enforce it.
  `MEEO_ASSERT_SAME(a_cfg_idle, cfg_taken, !busy, "config write while busy")

endmodule

bind matrix_elementary_ops_engine_top meeo_checker u_meeo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .done_o      (done_o),
  .result_o    (result_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

// ===== test/matrix_elementary_ops_engine_top_tb.sv =====
`timescale 1ns / 1ps

module matrix_elementary_ops_engine_top_tb;
  import meeo_pkg::*;

  localparam int Dim         = MaxDimDefault;
  localparam int MaxGap      = 17;
  localparam int ReportLimit = 10;
  localparam int CycleLimit  = 400000;
  // Longest command is a full-length swap; add some margin.
  localparam int DrainCycles = 2 * Dim + 8;
  localparam int RandPhases  = 12;
  localparam int PhaseItems  = 60;

  localparam logic signed [DataW-1:0] QMax    = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin    = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] QOne    = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] QNegOne = 32'shFFFF_0000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  cmd_t                cmd_i;
  logic                done_o;
  result_t             result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  // Shadow of the engine: every matrix word plus both dimension registers.
  logic signed [DataW-1:0] matrix_shadow [Dim*Dim];
  logic [CfgW-1:0]         row_limit;
  logic [CfgW-1:0]         col_limit;

  // Answers owed by the engine, oldest first.
  result_t answer_fifo [$];

  int  failures       = 0;
  int  accepted_items = 0;
  int  results_seen   = 0;
  int  range_rejects  = 0;
  int  equal_rejects  = 0;
  int  dim_settings   = 0;
  int  cycle_count    = 0;
  int  cmd_tally [8];
  bit  steady_feed    = 1'b0;

  matrix_elementary_ops_engine_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: end the run if the engine stops answering.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               answer_fifo.size());
      $display("matrix_elementary_ops_engine_top_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [DataW-1:0] clamp32(longint v);
    if (v > longint'(QMax)) return QMax;
    if (v < longint'(QMin)) return QMin;
    return v[DataW-1:0];
  endfunction

  // Q16.16 product, rounded toward minus infinity, then clamped.
  function automatic logic signed [DataW-1:0] mul_q16(logic signed [DataW-1:0] a,
                                                      logic signed [DataW-1:0] k);
    longint prod;
    prod = longint'(a) * longint'(k);
    return clamp32(prod >>> 16);
  endfunction

  function automatic int eff_dim(logic [CfgW-1:0] v);
    return (v > Dim) ? Dim : int'(v);
  endfunction

  // Apply one command to the shadow matrix and return the answer it owes.
  function automatic result_t apply_elementary_op(cmd_t c);
    result_t r;
    cmd_e    op;
    int      rows, cols, idim, plen, a, b, lo, hi, p, src, dst;
    bit      col_mode, bad, is_add, is_scale;
    logic signed [DataW-1:0] x;
    op       = cmd_e'(c.command);
    rows     = eff_dim(row_limit);
    cols     = eff_dim(col_limit);
    a        = c.first_index;
    b        = c.second_index;
    lo       = c.span_start;
    hi       = c.span_end;
    col_mode = (op == CMD_SWAP_COL || op == CMD_ADD_COL || op == CMD_SCALE_COL);
    is_add   = (op == CMD_ADD_ROW || op == CMD_ADD_COL);
    is_scale = (op == CMD_SCALE_ROW || op == CMD_SCALE_COL);
    // Indexes run over one dimension, the span over the other.
    idim     = col_mode ? cols : rows;
    plen     = col_mode ? rows : cols;
    r.read_value = '0;
    r.status     = STATUS_DONE;
    if (op == CMD_WRITE || op == CMD_READ) begin
      if (a >= rows || b >= cols) begin
        r.status = STATUS_RANGE;
      end else if (op == CMD_WRITE) begin
        matrix_shadow[a*Dim+b] = c.write_value;
      end else begin
        r.read_value = matrix_shadow[a*Dim+b];
      end
    end else begin
      // Scale ignores the second index entirely.
      bad = (a >= idim) || (!is_scale && b >= idim);
      if (hi > plen) hi = plen;
      if (bad) begin
        r.status = STATUS_RANGE;
      end else if (is_add && a == b) begin
        r.status = STATUS_EQUAL;
      end else begin
        for (p = lo; p < hi; p++) begin
          src = col_mode ? p*Dim + a : a*Dim + p;
          dst = col_mode ? p*Dim + b : b*Dim + p;
          if (is_add) begin
            matrix_shadow[dst] = clamp32(longint'(matrix_shadow[dst]) +
                                         longint'(mul_q16(matrix_shadow[src], c.factor)));
          end else if (is_scale) begin
            matrix_shadow[src] = mul_q16(matrix_shadow[src], c.factor);
          end else begin
            x                  = matrix_shadow[src];
            matrix_shadow[src] = matrix_shadow[dst];
            matrix_shadow[dst] = x;
          end
        end
      end
    end
    if (r.status == STATUS_RANGE) range_rejects++;
    if (r.status == STATUS_EQUAL) equal_rejects++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(string msg);
    failures++;
    if (failures <= ReportLimit) $display("%s", msg);
  endtask

  // done_o is a one-cycle strobe that cannot be held off: sample it at every edge.
  always @(posedge clk_i) begin : result_check
    result_t owed;
    if (rst_ni && done_o) begin
      results_seen++;
      if (answer_fifo.size() == 0) begin
        note_failure($sformatf("unexpected result: value %h status %0d",
                               result_o.read_value, result_o.status));
      end else begin
        owed = answer_fifo.pop_front();
        if (result_o.read_value !== owed.read_value || result_o.status !== owed.status)
          note_failure($sformatf("result %0d: want value %h status %0d, got value %h status %0d",
                                 results_seen, owed.read_value, owed.status,
                                 result_o.read_value, result_o.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one item after a random gap and hold it until the engine takes it.
  // start stays high on a zero gap so back-to-back items need no extra edge.
  task automatic send_item(cmd_t c);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    accepted_items++;
    cmd_tally[c.command]++;
    answer_fifo.push_back(apply_elementary_op(c));
  endtask

  // Drop start and wait until every owed answer has come back.
  task automatic settle_engine();
    start <= 1'b0;
    while (answer_fifo.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ROW_COUNT) row_limit = val;
    else col_limit = val;
    // Lower valid on its own edge so the next write never raises it in the same step.
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_dims(int rows, int cols);
    settle_engine();
    write_register(REG_ROW_COUNT, rows[CfgW-1:0]);
    write_register(REG_COL_COUNT, cols[CfgW-1:0]);
    dim_settings++;
  endtask

  function automatic cmd_t make_cmd(cmd_e op, int a, int b, logic [DataW-1:0] k,
                                    int lo, int hi, logic [DataW-1:0] wv);
    cmd_t c;
    c.command      = op;
    c.first_index  = a[IdxW-1:0];
    c.second_index = b[IdxW-1:0];
    c.factor       = k;
    c.span_start   = lo[SpanW-1:0];
    c.span_end     = hi[SpanW-1:0];
    c.write_value  = wv;
    return c;
  endfunction

  // Mostly values within +/-8.0, now and then full-width words and the bounds.
  function automatic logic [DataW-1:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? QMax : QMin;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // Mostly factors within +/-2.0, so the matrix neither blows up nor dies out.
  function automatic logic [DataW-1:0] draw_factor();
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       return QMax;
          1:       return QMin;
          2:       return '0;
          3:       return QNegOne;
          default: return QOne;
        endcase
      end
      2:       return QOne;
      default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  // Mostly in range for the current dimensions, sometimes anywhere.
  function automatic int pick_index(int lim);
    if (lim > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, lim - 1);
    return $urandom_range(0, Dim - 1);
  endfunction

  function automatic cmd_t draw_command();
    cmd_e op;
    int   rows, cols, a, b, lo, hi;
    bit   col_mode;
    // Extra weight on write and read keeps fresh data flowing through the matrix; row swap is weighted up too.
    op       = cmd_e'($urandom_range(0, 10) % 8);
    rows     = eff_dim(row_limit);
    cols     = eff_dim(col_limit);
    col_mode = (op == CMD_SWAP_COL || op == CMD_ADD_COL || op == CMD_SCALE_COL);
    if (op == CMD_WRITE || op == CMD_READ) begin
      a = pick_index(rows);
      b = pick_index(cols);
    end else begin
      a = pick_index(col_mode ? cols : rows);
      b = pick_index(col_mode ? cols : rows);
    end
    if ((op == CMD_ADD_ROW || op == CMD_ADD_COL) && $urandom_range(0, 9) == 0) b = a;
    lo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, Dim);
    case ($urandom_range(0, 7))
      0:       hi = $urandom_range(0, 31);
      1, 2:    hi = Dim;
      default: hi = $urandom_range(0, Dim);
    endcase
    return make_cmd(op, a, b, draw_factor(), lo, hi, draw_word());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Write every word once so no later command can touch an unwritten entry.
  task automatic test_fill_matrix();
    int r, c;
    for (r = 0; r < Dim; r++)
      for (c = 0; c < Dim; c++)
        send_item(make_cmd(CMD_WRITE, r, c, '0, 0, 0, draw_word()));
  endtask

  task automatic test_directed();
    // Corner words at both bounds, read back.
    send_item(make_cmd(CMD_WRITE, 0, 0, '0, 0, 0, QMax));
    send_item(make_cmd(CMD_WRITE, Dim-1, Dim-1, '0, 0, 0, QMin));
    send_item(make_cmd(CMD_READ, 0, 0, '0, 0, 0, '0));
    send_item(make_cmd(CMD_READ, Dim-1, Dim-1, '0, 0, 0, '0));
    // Saturate products upward and downward, and a sum past the top.
    send_item(make_cmd(CMD_SCALE_ROW, 0, 9, QMax, 0, Dim, '0));
    send_item(make_cmd(CMD_SCALE_COL, Dim-1, 0, QMin, 0, 31, '0));
    send_item(make_cmd(CMD_ADD_ROW, 0, Dim-1, 32'sh0002_0000, 0, Dim, '0));
    // Equal indices: add rejects, swap is a silent no-op.
    send_item(make_cmd(CMD_ADD_ROW, 3, 3, QOne, 0, Dim, '0));
    send_item(make_cmd(CMD_ADD_COL, 5, 5, QOne, 0, Dim, '0));
    send_item(make_cmd(CMD_SWAP_ROW, 2, 2, '0, 0, Dim, '0));
    send_item(make_cmd(CMD_SWAP_ROW, 1, Dim-2, '0, 0, Dim, '0));
    send_item(make_cmd(CMD_SWAP_COL, 0, Dim-1, '0, 4, 12, '0));
    send_item(make_cmd(CMD_ADD_COL, 2, 7, 32'shFFFE_8000, 0, Dim, '0));
    // Empty spans: equal bounds, start at the length, start past the length, start > end.
    send_item(make_cmd(CMD_SCALE_ROW, 4, 0, 32'sh0003_0000, 9, 9, '0));
    send_item(make_cmd(CMD_SCALE_COL, 6, 0, QNegOne, Dim, Dim, '0));
    send_item(make_cmd(CMD_SWAP_COL, 3, 8, '0, 31, 31, '0));
    send_item(make_cmd(CMD_SCALE_COL, 9, 3, QNegOne, 5, 2, '0));
    // End beyond the length is clipped; scale ignores the second index.
    send_item(make_cmd(CMD_SCALE_ROW, 8, Dim-1, 32'sh0000_8000, 3, 20, '0));
    send_item(make_cmd(CMD_READ, 0, 9, '0, 0, 0, '0));
    send_item(make_cmd(CMD_READ, 1, 0, '0, 0, 0, '0));
    send_item(make_cmd(CMD_READ, Dim-2, Dim-1, '0, 0, 0, '0));
    send_item(make_cmd(CMD_READ, Dim-1, 0, '0, 0, 0, '0));
    send_item(make_cmd(CMD_READ, 8, 2, '0, 0, 0, '0));
  endtask

  // Walk the dimension registers through their extremes, including zero
  // (every index out of range) and values above the maximum (clamped).
  task automatic test_dimensions();
    int row_set [9] = '{4, 0, 31, 1, Dim, 0, Dim, 17, Dim};
    int col_set [9] = '{9, 0, 31, Dim, 1, Dim, 0, 2, Dim};
    int i, n;
    for (i = 0; i < 9; i++) begin
      set_dims(row_set[i], col_set[i]);
      if (i == 0) begin
        // Four rows, nine columns: hit both range checks and the clipped span.
        send_item(make_cmd(CMD_WRITE, 5, 0, '0, 0, 0, QOne));
        send_item(make_cmd(CMD_SWAP_COL, 9, 1, '0, 0, Dim, '0));
        send_item(make_cmd(CMD_ADD_ROW, 1, 4, QOne, 0, Dim, '0));
        send_item(make_cmd(CMD_SCALE_ROW, 3, Dim-1, QNegOne, 0, Dim, '0));
        send_item(make_cmd(CMD_SCALE_COL, 8, 0, 32'sh0001_8000, 0, Dim, '0));
      end
      for (n = 0; n < 7; n++) send_item(draw_command());
    end
  endtask

  task automatic test_random();
    int phase, n;
    for (phase = 0; phase < RandPhases; phase++) begin
      if (phase == 0)
        set_dims(Dim, Dim);
      else if ($urandom_range(0, 4) == 0)
        set_dims($urandom_range(0, 31), $urandom_range(0, 31));
      else
        set_dims($urandom_range(1, Dim), $urandom_range(1, Dim));
      // Every third phase feeds items back to back.
      steady_feed = (phase % 3 == 1);
      for (n = 0; n < PhaseItems; n++) send_item(draw_command());
    end
    steady_feed = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    row_limit   = CountReset;
    col_limit   = CountReset;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_matrix();
    test_directed();
    test_dimensions();
    test_random();

    settle_engine();
    repeat (DrainCycles) @(posedge clk_i);
    if (answer_fifo.size() != 0)
      note_failure($sformatf("%0d answers never arrived", answer_fifo.size()));

    $display("%0d items, %0d answers, %0d dim settings, %0d range and %0d equal-index rejects",
             accepted_items, results_seen, dim_settings, range_rejects, equal_rejects);
    $display("per command: wr %0d rd %0d swr %0d swc %0d adr %0d adc %0d scr %0d scc %0d"
             , cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], cmd_tally[4],
             cmd_tally[5], cmd_tally[6], cmd_tally[7]);
    if (failures == 0) begin
      $display("matrix_elementary_ops_engine_top_tb OK");
    end else begin
      $display("matrix_elementary_ops_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule
